FILE: design/tea_block_cipher_macros.svh
// Assertion macros shared by the TEA block cipher RTL.
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TEA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TEA_ASSERT(label, clk, rst_n, prop, msg)
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/tea_pkg.sv
// Types, constants and round function of the TEA block cipher.
`timescale 1ns / 1ps

package tea_pkg;

	localparam int unsigned TEA_ROUNDS    = 16;
	localparam int unsigned TEA_WORD_W    = 32;
	localparam int unsigned TEA_KEY_WORDS = 4;
	localparam int unsigned TEA_CFG_IDX_W = 2;
	localparam logic [TEA_WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;
	localparam int unsigned TEA_SHL = 4;
	localparam int unsigned TEA_SHR = 5;

	typedef logic [TEA_WORD_W-1:0] tea_word_t;
	typedef logic [TEA_KEY_WORDS-1:0][TEA_WORD_W-1:0] tea_key_t;

	typedef enum logic [TEA_CFG_IDX_W-1:0] {
		CFG_KEY0 = 2'd0,
		CFG_KEY1 = 2'd1,
		CFG_KEY2 = 2'd2,
		CFG_KEY3 = 2'd3
	} tea_cfg_idx_t;

	// Request payload
	typedef struct packed {
		logic      req_type;
		tea_word_t block_first;
		tea_word_t block_second;
		logic      last_block;
	} tea_req_t;

	// Result payload
	typedef struct packed {
		tea_word_t out_first;
		tea_word_t out_second;
		logic      out_last;
	} tea_rsp_t;

	// Block state carried between pipeline stages
	typedef struct packed {
		logic      dec;
		tea_word_t y;
		tea_word_t z;
		logic      last;
	} tea_stage_t;

	// Running sum after n additions of delta, wrapped at 32 bits.
	function automatic tea_word_t tea_sum(input int unsigned n);
		tea_word_t s;
		s = '0;
		for (int unsigned i = 0; i < n; i++) begin
			s = s + TEA_DELTA;
		end
		return s;
	endfunction

	// One mixing of a half with the running sum and a key pair.
	function automatic tea_word_t tea_mix(input tea_word_t h, input tea_word_t sum,
		input tea_word_t ka, input tea_word_t kb);
		return ((h << TEA_SHL) + ka) ^ (h + sum) ^ ((h >> TEA_SHR) + kb);
	endfunction

endpackage

FILE: design/tea_stage.sv
// One half-round pipeline stage of the TEA block cipher.
`timescale 1ns / 1ps

module tea_stage import tea_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       half_sel,
	input  tea_word_t  sum_enc,
	input  tea_word_t  sum_dec,
	input  tea_key_t   key,
	input  logic       in_valid,
	input  tea_stage_t in_data,
	output logic       in_ready,
	output logic       out_valid,
	output tea_stage_t out_data,
	input  logic       out_ready
);

	logic       valid_s1;
	tea_stage_t data_s1;
	logic       upd_y;
	tea_word_t  src;
	tea_word_t  dst;
	tea_word_t  sum;
	tea_word_t  ka;
	tea_word_t  kb;
	tea_word_t  mixed;
	tea_word_t  dst_new;
	tea_stage_t nxt;

	// Encrypt updates y then z; decrypt updates z then y.
	assign upd_y = (half_sel == 1'b0) != in_data.dec;

	always_comb begin
		src     = upd_y ? in_data.z : in_data.y;
		dst     = upd_y ? in_data.y : in_data.z;
		sum     = in_data.dec ? sum_dec : sum_enc;
		ka      = upd_y ? key[CFG_KEY0] : key[CFG_KEY2];
		kb      = upd_y ? key[CFG_KEY1] : key[CFG_KEY3];
		mixed   = tea_mix(src, sum, ka, kb);
		dst_new = in_data.dec ? (dst - mixed) : (dst + mixed);
		nxt     = in_data;
		if (upd_y) begin
			nxt.y = dst_new;
		end else begin
			nxt.z = dst_new;
		end
	end

	// Take a new entry when empty or when the held one moves on.
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

FILE: design/tea_block_cipher.sv
// Top level of the pipelined TEA block cipher.
`timescale 1ns / 1ps
`include "tea_block_cipher_macros.svh"

// TEA block cipher, one 64-bit block per request. Each request carries two
// 32-bit words, a direction bit (0 encrypt, 1 decrypt) and a last-block flag
// that comes back unchanged with the result. The pipeline has 2*ROUNDS
// stages, one half-round (one mixing and one 32-bit add or subtract) each,
// so it takes one request every clock cycle when the result side does not
// stall, and each result is held in the last stage register until it is
// taken by the result side. Encryption and decryption share the stages:
// each stage picks its key pair and running-sum constant from the
// request's direction bit. A stall on the result side holds the last
// stage; upstream stages keep moving until they close up on it, so
// bubbles are squeezed out and req_stall rises only when every stage is
// full. The 128-bit key lives in four 32-bit registers written through
// the cfg port; write them only while no request is in flight.

module tea_block_cipher import tea_pkg::*; #(
	parameter int unsigned ROUNDS = TEA_ROUNDS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     req_valid,
	output logic                     req_stall,
	input  tea_req_t                 req_data,
	// result channel
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output tea_rsp_t                 rsp_data,
	// key registers
	input  logic                     cfg_wr_en,
	input  logic [TEA_CFG_IDX_W-1:0] cfg_index,
	input  tea_word_t                cfg_wdata
);

	localparam int unsigned NSTAGE = 2 * ROUNDS;

	tea_key_t   key_q;
	logic       stage_valid [0:NSTAGE];
	logic       stage_ready [0:NSTAGE];
	tea_stage_t stage_data  [0:NSTAGE];
	logic [NSTAGE-1:0] valid_vec;
	logic       req_accept;
	logic       rsp_accept;

	// Key registers: an index with no register behind it is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KEY0: key_q[CFG_KEY0] <= cfg_wdata;
				CFG_KEY1: key_q[CFG_KEY1] <= cfg_wdata;
				CFG_KEY2: key_q[CFG_KEY2] <= cfg_wdata;
				CFG_KEY3: key_q[CFG_KEY3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Feed the request into the head of the pipeline.
	assign stage_valid[0]    = req_valid;
	assign stage_data[0].dec  = req_data.req_type;
	assign stage_data[0].y    = req_data.block_first;
	assign stage_data[0].z    = req_data.block_second;
	assign stage_data[0].last = req_data.last_block;
	assign req_stall          = !stage_ready[0];

	// Half-round stages: stage 2r is the first half of round r, 2r+1 the second.
	// Encrypt uses sum delta*(r+1); decrypt walks back from delta*ROUNDS.
	for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
		tea_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.half_sel  (1'(j % 2)),
			.sum_enc   (tea_sum(j / 2 + 1)),
			.sum_dec   (tea_sum(ROUNDS - j / 2)),
			.key       (key_q),
			.in_valid  (stage_valid[j]),
			.in_data   (stage_data[j]),
			.in_ready  (stage_ready[j]),
			.out_valid (stage_valid[j+1]),
			.out_data  (stage_data[j+1]),
			.out_ready (stage_ready[j+1])
		);
		assign valid_vec[j] = stage_valid[j+1];
	end

	// The last stage register is the result register.
	assign stage_ready[NSTAGE] = !rsp_stall;
	assign rsp_valid           = stage_valid[NSTAGE];
	assign rsp_data.out_first  = stage_data[NSTAGE].y;
	assign rsp_data.out_second = stage_data[NSTAGE].z;
	assign rsp_data.out_last   = stage_data[NSTAGE].last;

	assign req_accept = req_valid && !req_stall;
	assign rsp_accept = rsp_valid && !rsp_stall;

	// Stage occupancy moves only by accepted requests and delivered results.
	`TEA_ASSERT(a_occupancy, clk, arst_n, $past(arst_n) |-> ($countones(valid_vec) == $countones($past(valid_vec)) + $past(req_accept) - $past(rsp_accept)), "pipeline occupancy lost or gained an entry")
	// Back-pressure reaches the request side only from a held result.
	`TEA_ASSERT(a_stall_source, clk, arst_n, req_stall |-> (rsp_valid && rsp_stall), "request stalled with no held result")
	// A write to key word 3 lands in its register.
	`TEA_ASSERT_NEXT(a_key_write, clk, arst_n, arst_n && cfg_wr_en && cfg_index == CFG_KEY3, key_q[CFG_KEY3] == $past(cfg_wdata), "key word 3 write not stored")

endmodule
